// ===== hw/rtl/moving_average_3axis_defines.svh =====
// Assertion macros for the moving_average_3axis checker.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef MOVING_AVERAGE_3AXIS_DEFINES_SVH
`define MOVING_AVERAGE_3AXIS_DEFINES_SVH

// same-cycle implication
`define MAV3_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("moving_average_3axis check failed");

// next-cycle implication
`define MAV3_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("moving_average_3axis check failed");

`endif

// ===== hw/rtl/mav3_pkg.sv =====
// Shared constants, types and divider reciprocal for moving_average_3axis.
// Depends on nothing.
package mav3_pkg;

	localparam int AXES     = 3;
	localparam int SAMPLE_W = 16;
	localparam int WINDOW   = 20;

	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	// largest window sum magnitude and the widths that follow from it
	localparam longint unsigned MAG_MAX = longint'(WINDOW) << (SAMPLE_W - 1);
	localparam int MAG_W = $clog2(MAG_MAX + 1);
	localparam int SUM_W = MAG_W + 1;

	// reciprocal of WINDOW, exact for every magnitude below 2**MAG_W
	localparam int RECIP_SHIFT = MAG_W + $clog2(WINDOW);
	localparam longint unsigned RECIP_VAL =
		((64'd1 << RECIP_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
	localparam int RECIP_W = $clog2(RECIP_VAL + 1);
	localparam int PROD_W  = MAG_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];

	typedef logic [AXES-1:0][SAMPLE_W-1:0] triple_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

endpackage

// ===== hw/rtl/mav3_in_if.sv =====
// Input channel: one three-axis sample word with valid/ready.
// Depends on mav3_pkg.
interface mav3_in_if;
	import mav3_pkg::*;

	logic    valid;
	logic    ready;
	sample_t accel_x;
	sample_t accel_y;
	sample_t accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

// ===== hw/rtl/mav3_out_if.sv =====
// Output channel: one three-axis average word with valid/ready.
// Depends on mav3_pkg.
interface mav3_out_if;
	import mav3_pkg::*;

	logic    valid;
	logic    ready;
	sample_t avg_x;
	sample_t avg_y;
	sample_t avg_z;

	modport source (output valid, output avg_x, output avg_y, output avg_z, input ready);
	modport sink   (input valid, input avg_x, input avg_y, input avg_z, output ready);
endinterface

// ===== hw/rtl/mav3_cell.sv =====
// One cell of the sample delay line: holds a three-axis sample and
// hands it to the next cell on each accepted word. Depends on mav3_pkg.
module mav3_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  mav3_pkg::triple_t d,
	output mav3_pkg::triple_t q
);
	import mav3_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= d;
		end
	end
endmodule

// ===== hw/rtl/mav3_div.sv =====
// Signed divide of one axis window sum by WINDOW, truncating toward zero.
// Two stages: reciprocal multiply, then shift and sign restore. Depends on mav3_pkg.
module mav3_div (
	input  logic                clk,
	input  mav3_pkg::pipe_ctl_t ctl,
	input  mav3_pkg::sum_t      sum,
	output mav3_pkg::sample_t   avg
);
	import mav3_pkg::*;

	logic [SUM_W-1:0]    abs_v;
	logic [MAG_W-1:0]    mag;
	logic [PROD_W-1:0]   prod_s2;
	logic                neg_s2;
	logic [SAMPLE_W-1:0] quo;
	sample_t             avg_s3;

	assign abs_v = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	assign mag   = abs_v[MAG_W-1:0];
	assign quo   = prod_s2[RECIP_SHIFT +: SAMPLE_W];

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			neg_s2  <= sum[SUM_W-1];
			prod_s2 <= PROD_W'(mag) * PROD_W'(RECIP);
		end
		if (ctl.en_s3) begin
			avg_s3 <= neg_s2 ? sample_t'(-quo) : sample_t'(quo);
		end
	end

	assign avg = avg_s3;
endmodule

// ===== hw/rtl/moving_average_3axis.sv =====
// Boxcar moving average over the last WINDOW three-axis samples.
// Pipeline: running sums, then divider product, then average output register.
// Throughput: one word per cycle unless stalled; the running sums update once per accepted word.
// Stages stall independently; a held output word blocks intake once all three stages are full.
// Reset clears the sample delay line, running sums and valid bits; data registers are not reset.
module moving_average_3axis (
	input  logic        clk,
	input  logic        arst_n,
	mav3_in_if.sink     accel,
	mav3_out_if.source  avg
);
	import mav3_pkg::*;

	triple_t   chain [0:WINDOW];
	sum_t      sum_q [AXES];
	sample_t   avg_v [AXES];
	logic      v_s1, v_s2, v_s3;
	logic      en1;
	logic      take;
	pipe_ctl_t ctl;

	assign ctl.en_s3 = !v_s3 || avg.ready;
	assign ctl.en_s2 = !v_s2 || ctl.en_s3;
	assign en1       = !v_s1 || ctl.en_s2;
	assign accel.ready = en1;
	assign take      = accel.valid && en1;

	assign chain[0][AX_X] = accel.accel_x;
	assign chain[0][AX_Y] = accel.accel_y;
	assign chain[0][AX_Z] = accel.accel_z;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		mav3_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (take),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	// running sums: add newest, drop the sample leaving the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else if (take) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= sum_q[a] + SUM_W'($signed(chain[0][a]))
					- SUM_W'($signed(chain[WINDOW][a]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accel.valid;
			end
			if (ctl.en_s2) begin
				v_s2 <= v_s1;
			end
			if (ctl.en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_div
		mav3_div u_div (
			.clk (clk),
			.ctl (ctl),
			.sum (sum_q[a]),
			.avg (avg_v[a])
		);
	end

	assign avg.valid = v_s3;
	assign avg.avg_x = avg_v[AX_X];
	assign avg.avg_y = avg_v[AX_Y];
	assign avg.avg_z = avg_v[AX_Z];
endmodule

// ===== hw/rtl/mav3_checker.sv =====
// Port-level checks for moving_average_3axis, attached by bind.
// Depends on mav3_pkg, the channel interfaces and moving_average_3axis_defines.svh.
`include "moving_average_3axis_defines.svh"

module mav3_checker (
	input  logic       clk,
	input  logic       arst_n,
	mav3_in_if.sink    accel,
	mav3_out_if.source avg
);
	import mav3_pkg::*;

	// a stalled output word holds
	`MAV3_ASSERT_NXT(a_out_hold, avg.valid && !avg.ready, avg.valid && $stable(avg.avg_x) && $stable(avg.avg_y) && $stable(avg.avg_z))

	// with the output draining, intake is never blocked
	`MAV3_ASSERT_IMP(a_ready_when_drain, avg.ready, accel.ready)

	// intake only stops when every stage holds a word and the output stalls
	`MAV3_ASSERT_IMP(a_full_when_blocked, !accel.ready, avg.valid && !avg.ready)

	// an accepted word reaches the output when the output keeps draining meanwhile
	`MAV3_ASSERT_NXT(a_latency, (accel.valid && accel.ready) ##1 avg.ready ##1 avg.ready, avg.valid)
endmodule

bind moving_average_3axis mav3_checker u_mav3_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.accel  (accel),
	.avg    (avg)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for moving_average_3axis: drives sample words, predicts window averages.
// Depends on mav3_pkg, mav3_in_if, mav3_out_if and the moving_average_3axis RTL.
module tb;
	import mav3_pkg::*;

	localparam int LATENCY = 3;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		sample_t ax;
		sample_t ay;
		sample_t az;
	} avg_word_t;

	logic clk = 1'b0;
	logic arst_n;

	mav3_in_if  accel_bus();
	mav3_out_if avg_bus();

	moving_average_3axis DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.accel  (accel_bus),
		.avg    (avg_bus)
	);

	always #5 clk = ~clk;

	// predictor state
	sample_t   hist [AXES][WINDOW];
	int        win_sum [AXES];
	int        wr_pos;
	avg_word_t avg_expect_q[$];

	int err_cnt = 0;
	int burst_left = 0;
	bit send_idle_en = 1'b1;
	bit recv_stall_en = 1'b1;
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	int stall_mode = 0;
	int mode_left = 0;

	task automatic clear_predictor();
		for (int a = 0; a < AXES; a++) begin
			win_sum[a] = 0;
			for (int i = 0; i < WINDOW; i++)
				hist[a][i] = '0;
		end
		wr_pos = 0;
	endtask

	task automatic predict_average(input sample_t sx, input sample_t sy, input sample_t sz);
		sample_t   s [AXES];
		sample_t   q [AXES];
		avg_word_t w;
		s[AX_X] = sx;
		s[AX_Y] = sy;
		s[AX_Z] = sz;
		for (int a = 0; a < AXES; a++) begin
			win_sum[a] = win_sum[a] + int'(s[a]) - int'(hist[a][wr_pos]);
			hist[a][wr_pos] = s[a];
			q[a] = sample_t'(win_sum[a] / WINDOW);
		end
		wr_pos = (wr_pos == WINDOW - 1) ? 0 : wr_pos + 1;
		w.ax = q[AX_X];
		w.ay = q[AX_Y];
		w.az = q[AX_Z];
		avg_expect_q.push_back(w);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
		err_cnt++;
	endtask

	// one sample word; valid stays high across back-to-back words
	task automatic send_word(input sample_t sx, input sample_t sy, input sample_t sz);
		int gap;
		@(negedge clk);
		if (send_idle_en && burst_left == 0) begin
			accel_bus.valid <= 1'b0;
			gap = $urandom_range(6, 1);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(16, 1);
		end
		if (send_idle_en)
			burst_left--;
		accel_bus.valid   <= 1'b1;
		accel_bus.accel_x <= sx;
		accel_bus.accel_y <= sy;
		accel_bus.accel_z <= sz;
		do @(posedge clk); while (!accel_bus.ready);
		predict_average(sx, sy, sz);
	endtask

	task automatic release_input();
		@(negedge clk);
		accel_bus.valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (avg_expect_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	function automatic sample_t rand_sample();
		return sample_t'($urandom);
	endfunction

	function automatic sample_t near_zero();
		return sample_t'(int'($urandom_range(80)) - 40);
	endfunction

	function automatic sample_t rand_extreme();
		return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
	endfunction

	// full windows at both extremes, then the write position wraps
	task automatic test_extremes();
		for (int i = 0; i < WINDOW; i++)
			send_word(16'sh7fff, 16'sh8000, 16'sh7fff);
		send_word(16'sh8000, 16'sh7fff, 16'sh0000);
		send_word(16'shffff, 16'sh0001, 16'shffec);
		send_word(16'sh8000, 16'sh7fff, 16'sh0013);
		release_input();
		wait_drain();
	endtask

	task automatic test_random(input int n_items);
		int cnt;
		int kind;
		int run_len;
		sample_t cx, cy, cz;
		cnt = 0;
		while (cnt < n_items) begin
			if ($urandom_range(40) == 0) begin
				send_idle_en = 1'($urandom_range(1));
				recv_stall_en = 1'($urandom_range(1));
			end
			kind = $urandom_range(9);
			if (kind < 3) begin
				send_word(rand_sample(), rand_sample(), rand_sample());
				cnt++;
			end else if (kind < 6) begin
				// runs of constant extremes, up to twice the window length
				cx = rand_extreme();
				cy = rand_extreme();
				cz = rand_extreme();
				run_len = $urandom_range(2 * WINDOW, 1);
				for (int i = 0; i < run_len; i++)
					send_word(cx, cy, cz);
				cnt += run_len;
			end else if (kind < 9) begin
				// small values around zero exercise truncation toward zero
				run_len = $urandom_range(WINDOW + 5, 1);
				for (int i = 0; i < run_len; i++)
					send_word(near_zero(), near_zero(), near_zero());
				cnt += run_len;
			end else begin
				send_word(rand_extreme(), near_zero(), rand_sample());
				cnt++;
			end
		end
		send_idle_en = 1'b1;
		recv_stall_en = 1'b1;
		release_input();
		wait_drain();
	endtask

	task automatic test_backpressure();
		send_idle_en = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_word(rand_sample(), rand_sample(), rand_sample());
		send_idle_en = 1'b1;
		release_input();
		wait_drain();
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 25; i++)
			send_word(rand_sample(), near_zero(), rand_extreme());
		release_input();
		wait_drain();
		for (int i = 0; i < 25; i++)
			send_word(near_zero(), rand_sample(), rand_sample());
		release_input();
		wait_drain();
	endtask

	// receiver: long hold on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(3);
			mode_left = $urandom_range(200, 20);
		end
		mode_left--;
		if (hold_cnt > 0) begin
			hold_cnt--;
			avg_bus.ready <= 1'b0;
		end else if (!recv_stall_en || stall_mode == 0) begin
			avg_bus.ready <= 1'b1;
		end else if (stall_mode == 1) begin
			avg_bus.ready <= 1'($urandom_range(1));
		end else if (stall_mode == 2) begin
			avg_bus.ready <= ($urandom_range(3) != 0);
		end else begin
			avg_bus.ready <= (mode_left % 4 != 0);
		end
	end

	always @(posedge clk) begin
		avg_word_t w;
		if (arst_n && avg_bus.valid && avg_bus.ready) begin
			if (avg_expect_q.size() == 0) begin
				report_mismatch("unexpected word avg_x", int'(avg_bus.avg_x), 0);
			end else begin
				w = avg_expect_q.pop_front();
				if (avg_bus.avg_x !== w.ax)
					report_mismatch("avg_x", int'(avg_bus.avg_x), int'(w.ax));
				if (avg_bus.avg_y !== w.ay)
					report_mismatch("avg_y", int'(avg_bus.avg_y), int'(w.ay));
				if (avg_bus.avg_z !== w.az)
					report_mismatch("avg_z", int'(avg_bus.avg_z), int'(w.az));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		accel_bus.valid = 1'b0;
		accel_bus.accel_x = '0;
		accel_bus.accel_y = '0;
		accel_bus.accel_z = '0;
		avg_bus.ready = 1'b0;
		clear_predictor();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_random(400);
		test_backpressure();
		test_drain_pause();

		wait_drain();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mav3_pkg.sv
hw/rtl/mav3_in_if.sv
hw/rtl/mav3_out_if.sv
hw/rtl/mav3_cell.sv
hw/rtl/mav3_div.sv
hw/rtl/moving_average_3axis.sv
hw/rtl/mav3_checker.sv
test/tb.sv
